// ----- src/ihf2ieee_pkg.sv -----
package ihf2ieee_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned FRAC_W  = 24;
	localparam int unsigned HEXE_W  = 7;
	localparam int unsigned LZ_W    = 5;
	localparam int unsigned MANT_W  = 23;
	localparam int unsigned EXPF_W  = 8;
	localparam int unsigned BEXP_W  = 10;

	typedef logic signed [BEXP_W-1:0] bexp_t;
	typedef logic [LZ_W-1:0]          lz_t;
	typedef logic [FRAC_W-1:0]        frac_t;

	localparam bexp_t EXP_OFFSET   = bexp_t'(130);
	localparam bexp_t EXP_MAX      = bexp_t'(255);
	localparam bexp_t DENORM_LIMIT = bexp_t'(-24);
	localparam bexp_t BEXP_ZERO    = bexp_t'(0);
	localparam bexp_t BEXP_ONE     = bexp_t'(1);

endpackage

// ----- src/ihf2ieee_if.sv -----
interface ihf2ieee_in_if import ihf2ieee_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] ibm_word;

	modport source (output valid, output ibm_word, input ready);
	modport sink (input valid, input ibm_word, output ready);
endinterface

interface ihf2ieee_out_if import ihf2ieee_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] ieee_word;

	modport source (output valid, output ieee_word, input ready);
	modport sink (input valid, input ieee_word, output ready);
endinterface

// ----- src/ibm_hex_float_to_ieee_single.sv -----
// Throughput: one request per cycle; the whole pipe holds while the output stalls.
// Stages: input register, leading-zero count, normalize shift and exponent,
// classify with denormal shift into the output register.
// Reset (arst_n, asynchronous) clears the stage valid bits only.
module ibm_hex_float_to_ieee_single import ihf2ieee_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	ihf2ieee_in_if.sink    in_ch,
	ihf2ieee_out_if.source out_ch
);

	logic advance;

	logic              valid_s1, valid_s2, valid_s3, valid_s4;
	logic              sign_s1, sign_s2, sign_s3;
	logic [HEXE_W-1:0] hexe_s1, hexe_s2;
	frac_t             frac_s1, frac_s2, norm_s3;
	lz_t               lz_s2;
	logic              zero_s2, zero_s3;
	bexp_t             bexp_s3;
	logic [WORD_W-1:0] word_s4;

	lz_t               lz_s1;
	bexp_t             bexp_n;
	logic [LZ_W-1:0]   shamt;
	logic [EXPF_W-1:0] expf_n;
	logic [MANT_W-1:0] mant_n;

	// every stage moves together; hold all when the result is not taken
	assign advance     = !valid_s4 || out_ch.ready;
	assign in_ch.ready = advance;

	assign out_ch.valid     = valid_s4;
	assign out_ch.ieee_word = word_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_ch.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// stage 1: capture
	always_ff @(posedge clk) begin
		if (advance) begin
			sign_s1 <= in_ch.ibm_word[WORD_W-1];
			hexe_s1 <= in_ch.ibm_word[WORD_W-2 -: HEXE_W];
			frac_s1 <= in_ch.ibm_word[FRAC_W-1:0];
		end
	end

	// stage 2: leading-zero count
	ihf2ieee_lzc u_lzc (
		.frac (frac_s1),
		.lz   (lz_s1)
	);

	always_ff @(posedge clk) begin
		if (advance) begin
			sign_s2 <= sign_s1;
			hexe_s2 <= hexe_s1;
			frac_s2 <= frac_s1;
			lz_s2   <= lz_s1;
			zero_s2 <= (frac_s1 == '0);
		end
	end

	// stage 3: normalize and form the biased exponent
	assign bexp_n = $signed({{(BEXP_W-HEXE_W-2){1'b0}}, hexe_s2, 2'b00})
		- EXP_OFFSET - $signed({{(BEXP_W-LZ_W){1'b0}}, lz_s2});

	always_ff @(posedge clk) begin
		if (advance) begin
			sign_s3 <= sign_s2;
			zero_s3 <= zero_s2;
			norm_s3 <= frac_s2 << lz_s2;
			bexp_s3 <= bexp_n;
		end
	end

	// stage 4: classify; a denormal shifts the full mantissa right by 1 - bexp
	assign shamt = LZ_W'(BEXP_ONE - bexp_s3);

	always_comb begin
		priority if (zero_s3 || bexp_s3 < DENORM_LIMIT) begin
			expf_n = '0;
			mant_n = '0;
		end else if (bexp_s3 <= BEXP_ZERO) begin
			expf_n = '0;
			mant_n = MANT_W'(norm_s3 >> shamt);
		end else if (bexp_s3 >= EXP_MAX) begin
			expf_n = EXPF_W'(EXP_MAX);
			mant_n = '0;
		end else begin
			expf_n = EXPF_W'(bexp_s3);
			mant_n = norm_s3[MANT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			word_s4 <= {sign_s3, expf_n, mant_n};
		end
	end

endmodule

// ----- src/ihf2ieee_lzc.sv -----
module ihf2ieee_lzc import ihf2ieee_pkg::*; (
	input  frac_t frac,
	output lz_t   lz
);

	// scan from the LSB up so the highest set bit wins
	always_comb begin
		lz = '0;
		for (int i = 0; i < FRAC_W; i++) begin
			if (frac[i]) begin
				lz = lz_t'(FRAC_W - 1 - i);
			end
		end
	end

endmodule

// ----- test/testbench.sv -----
module testbench import ihf2ieee_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RESET_CYCLES  = 11;
	localparam int unsigned IDLE_PERCENT  = 20;
	localparam int unsigned DRAIN_CYCLES  = 20;
	localparam int unsigned RUN_LIMIT_NS  = 200_000;

	logic clk;
	logic arst_n;

	ihf2ieee_in_if  in_ch ();
	ihf2ieee_out_if out_ch ();

	ibm_hex_float_to_ieee_single u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	logic [WORD_W-1:0] pending_words[$];
	int unsigned       fail_count;
	bit                steady;

	// IBM short hex float to IEEE single, mantissa truncated
	function automatic logic [WORD_W-1:0] ieee_of_ibm(input logic [WORD_W-1:0] word);
		logic              sign;
		logic [HEXE_W-1:0] hexexp;
		logic [WORD_W-1:0] mant;
		int                bexp;
		logic [EXPF_W-1:0] efield;
		logic [MANT_W-1:0] mfield;
		sign   = word[WORD_W-1];
		hexexp = word[WORD_W-2 -: HEXE_W];
		mant   = {word[FRAC_W-1:0], 8'h00};
		if (mant == '0)
			return {sign, {(WORD_W-1){1'b0}}};
		bexp = 4 * int'(hexexp) - int'(EXP_OFFSET);
		while (!mant[WORD_W-1]) begin
			mant = mant << 1;
			bexp--;
		end
		if (bexp <= 0) begin
			efield = '0;
			if (bexp < int'(DENORM_LIMIT))
				mfield = '0;
			else
				mfield = MANT_W'((mant >> (-bexp)) >> (WORD_W - MANT_W));
		end else if (bexp >= int'(EXP_MAX)) begin
			efield = EXPF_W'(EXP_MAX);
			mfield = '0;
		end else begin
			efield = EXPF_W'(bexp);
			mfield = mant[WORD_W-2 -: MANT_W];
		end
		return {sign, efield, mfield};
	endfunction

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("TB_ERROR");
		$finish;
	end

	// Expects to be called in the time step of a rising edge
	task automatic send_request(input logic [WORD_W-1:0] word);
		logic taken;
		while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid    <= 1'b1;
		in_ch.ibm_word <= word;
		do begin
			@(negedge clk);
			taken = in_ch.ready;
			@(posedge clk);
		end while (!taken);
		pending_words.push_back(ieee_of_ibm(word));
	endtask

	// Sample at the falling edge, where handshake signals are settled
	initial begin
		logic [WORD_W-1:0] want;
		out_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (arst_n && out_ch.valid && out_ch.ready) begin
				if (pending_words.size() == 0) begin
					$error("ieee_word: no result expected, actual %h", out_ch.ieee_word);
					fail_count++;
				end else begin
					want = pending_words.pop_front();
					if (out_ch.ieee_word !== want) begin
						$error("ieee_word: expected %h, actual %h", want, out_ch.ieee_word);
						fail_count++;
					end
				end
			end
			@(posedge clk);
			out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	task automatic run_directed_corners();
		logic [WORD_W-1:0] corners[$];
		corners = '{
			32'h0000_0000, 32'h8000_0000, 32'h7F00_0000, 32'hC500_0000,
			32'h4110_0000, 32'hC110_0000, 32'h4000_0001, 32'h0000_0001,
			32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h4100_0001, 32'h42FF_FFFF,
			32'h2140_0000, 32'h2120_0000, 32'h2080_0000, 32'hA0FF_FFFF,
			32'h1B20_0000, 32'h9B3F_FFFF, 32'h1B10_0000, 32'h1AFF_FFFF,
			32'h6110_0000, 32'h6108_0000, 32'hE1FF_FFFF, 32'h4055_AA55
		};
		foreach (corners[i])
			send_request(corners[i]);
	endtask

	task automatic run_random_words(input int unsigned count);
		repeat (count)
			send_request($urandom);
	endtask

	// Aim exponents at the denormal and overflow boundaries, or draw them over the full range
	task automatic run_edge_exponents(input int unsigned count);
		logic [HEXE_W-1:0] hexexp;
		logic [FRAC_W-1:0] frac;
		repeat (count) begin
			case ($urandom_range(2))
				0: hexexp = HEXE_W'($urandom_range(25, 33));
				1: hexexp = HEXE_W'($urandom_range(94, 97));
				default: hexexp = HEXE_W'($urandom_range(127));
			endcase
			frac = FRAC_W'($urandom) >> $urandom_range(FRAC_W - 1);
			send_request({1'($urandom), hexexp, frac});
		end
	endtask

	task automatic run_back_to_back(input int unsigned count);
		steady = 1'b1;
		repeat (count)
			send_request($urandom);
		steady = 1'b0;
	endtask

	initial begin
		fail_count = 0;
		steady     = 1'b0;
		arst_n     = 1'b0;
		in_ch.valid    <= 1'b0;
		in_ch.ibm_word <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		run_directed_corners();
		run_random_words(250);
		run_edge_exponents(280);
		run_back_to_back(200);

		in_ch.valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/ihf2ieee_pkg.sv
src/ihf2ieee_if.sv
src/ihf2ieee_lzc.sv
src/ibm_hex_float_to_ieee_single.sv
test/testbench.sv
